FILE: hdl/lfd_pkg.sv
// lfd_pkg: shared types and constants for the linear fade dimmer.
// Used by lfd_mul, lfd_div, linear_fade_dimmer, lfd_checker and tb. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfd_pkg;

   localparam int unsigned PCT_W  = 7;   // integer percent, 0..100
   localparam int unsigned DATA_W = 16;  // drive value, elapsed ms, span
   localparam int unsigned MS_W   = 24;  // fade length / divisor width
   localparam int unsigned ADDR_W = 3;   // two 32-bit registers

   localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
   localparam logic [MS_W-1:0]  DRIVE_DIV = 24'd100;

   // command codes
   localparam logic [1:0] CMD_SET  = 2'd0;
   localparam logic [1:0] CMD_FADE = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // register index, taken from paddr[2]
   localparam logic REG_OUT_MIN = 1'b0;
   localparam logic REG_OUT_MAX = 1'b1;

   typedef struct packed {
      logic [1:0]               cmd;
      logic signed [DATA_W-1:0] level;
      logic signed [DATA_W-1:0] fade_start;
      logic signed [DATA_W-1:0] fade_stop;
      logic [MS_W-1:0]          fade_ms;
      logic [DATA_W-1:0]        elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] drive_value;
      logic [PCT_W-1:0]  level_pct;
      logic              fading;
   } rsp_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

`default_nettype wire

FILE: hdl/lfd_mul.sv
// lfd_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on lfd_pkg (DATA_W, unit_stat_type).
`timescale 1ns / 1ps
`default_nettype none

module lfd_mul #(
   parameter int unsigned A_W = 31
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [A_W-1:0]                 mcand,
   input  wire logic [lfd_pkg::DATA_W-1:0]     mplier,
   output logic [A_W+lfd_pkg::DATA_W-1:0]      prod,
   output lfd_pkg::unit_stat_type              stat
);

   localparam int unsigned B_W   = lfd_pkg::DATA_W;
   localparam int unsigned P_W   = A_W + B_W;
   localparam int unsigned CNT_W = $clog2(B_W + 1);

   logic [P_W-1:0]   acc_ff, acc_in;
   logic [B_W-1:0]   sh_ff, sh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   // MSB-first: shift the partial product, add the multiplicand on a one
   always_comb begin
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         sh_in  = mplier;
         cnt_in = CNT_W'(B_W);
      end else if (cnt_ff != '0) begin
         acc_in  = {acc_ff[P_W-2:0], 1'b0} + (sh_ff[B_W-1] ? P_W'(mcand) : '0);
         sh_in   = {sh_ff[B_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign prod      = acc_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

`default_nettype wire

FILE: hdl/lfd_div.sv
// lfd_div: restoring divider, one quotient bit per cycle.
// Depends on lfd_pkg (MS_W, unit_stat_type).
`timescale 1ns / 1ps
`default_nettype none

module lfd_div #(
   parameter int unsigned N_W = 31
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [N_W-1:0]               dividend,
   input  wire logic [lfd_pkg::MS_W-1:0]     divisor,
   output logic [N_W-1:0]                    quo,
   output lfd_pkg::unit_stat_type            stat
);

   localparam int unsigned D_W   = lfd_pkg::MS_W;
   localparam int unsigned CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial, diff;
   logic             ge;

   // dividend shifts out of quo_ff MSB while quotient bits enter at the LSB
   assign trial = {rem_ff, quo_ff[N_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = (trial >= {1'b0, divisor});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(N_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[N_W-2:0], ge};
         rem_in  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

`default_nettype wire

FILE: hdl/linear_fade_dimmer.sv
// linear_fade_dimmer: lamp dimmer with set, linear fade and tick commands.
// Depends on lfd_pkg, lfd_mul and lfd_div.
//
//   channel   ports                          handshake
//   req       req_valid/req_stall/req_data   transaction when valid & !stall
//   rsp       rsp_valid/rsp_stall/rsp_data   transaction when valid & !stall
//   csr       psel/penable/pwrite/paddr/...  write on psel & penable & pwrite
//
// One item at a time; L = 7 + FRAC_BITS. The shared serial multiplier takes an
// L-bit multiplicand and the shared serial divider an L-bit dividend; a set
// out of range skips both and goes straight to the output.
// Synchronous reset clears level, step and target, sets out_min to 0 and out_max to 255.
// A result waits in the output register while the next item is taken; a
// finished item stalls only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module linear_fade_dimmer #(
   parameter int unsigned FRAC_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire lfd_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output lfd_pkg::rsp_type                   rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lfd_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int unsigned PCT_W  = lfd_pkg::PCT_W;
   localparam int unsigned DATA_W = lfd_pkg::DATA_W;
   localparam int unsigned LVL_W  = PCT_W + FRAC_BITS;
   localparam int unsigned PROD_W = LVL_W + DATA_W;
   localparam logic [LVL_W-1:0] LVL_TOP = {lfd_pkg::PCT_MAX, {FRAC_BITS{1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_TICK_MUL, ST_STEP_DIV, ST_DRV_MUL, ST_DRV_DIV, ST_EMIT
   } state_type;

   function automatic logic [PCT_W-1:0] clamp_pct(input logic signed [DATA_W-1:0] p);
      priority if (p[DATA_W-1])          return '0;
      else if (p > $signed(16'sd100))    return lfd_pkg::PCT_MAX;
      else                               return p[PCT_W-1:0];
   endfunction

   function automatic logic [LVL_W-1:0] pct_lvl(input logic [PCT_W-1:0] p);
      return {p, {FRAC_BITS{1'b0}}};
   endfunction

   // ---------------------------------------------------------------- csr
   logic [DATA_W-1:0] out_min_ff, out_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_min_ff <= '0;
         out_max_ff <= 16'd255;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == lfd_pkg::REG_OUT_MAX) out_max_ff <= pwdata[DATA_W-1:0];
         else                                  out_min_ff <= pwdata[DATA_W-1:0];
      end
   end

   assign prdata = {16'd0, (paddr[2] == lfd_pkg::REG_OUT_MAX) ? out_max_ff : out_min_ff};
   assign pready = 1'b1;

   // ---------------------------------------------------------------- datapath
   state_type             state_ff, state_in;
   logic [LVL_W-1:0]      level_ff, level_in;
   logic [LVL_W-1:0]      step_mag_ff, step_mag_in;
   logic                  step_neg_ff, step_neg_in;
   logic [PCT_W-1:0]      stop_ff, stop_in;
   logic [DATA_W-1:0]     drive_ff, drive_in;
   logic [LVL_W-1:0]      mul_a_ff, mul_a_in;
   logic [DATA_W-1:0]     mul_b_ff, mul_b_in;
   logic                  mul_start_ff, mul_start_in;
   logic [LVL_W-1:0]      div_n_ff, div_n_in;
   logic [lfd_pkg::MS_W-1:0] div_d_ff, div_d_in;
   logic                  div_start_ff, div_start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lfd_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic [PROD_W-1:0]     mul_prod;
   logic [LVL_W-1:0]      div_quo;
   lfd_pkg::unit_stat_type mul_stat, div_stat;

   logic [PCT_W-1:0]      set_pct, start_pct, stop_pct, diff_mag;
   logic [PROD_W:0]       up_sum;
   logic [LVL_W-1:0]      tick_lvl, lim;
   logic                  tick_end;
   logic                  span_ok;
   logic [DATA_W-1:0]     span;
   logic                  drv_go;
   logic [LVL_W-1:0]      drv_lvl;

   lfd_mul #(.A_W(LVL_W)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start_ff),
      .mcand  (mul_a_ff),
      .mplier (mul_b_ff),
      .prod   (mul_prod),
      .stat   (mul_stat)
   );

   lfd_div #(.N_W(LVL_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .quo      (div_quo),
      .stat     (div_stat)
   );

   assign set_pct   = clamp_pct(req_data.level);
   assign start_pct = clamp_pct(req_data.fade_start);
   assign stop_pct  = clamp_pct(req_data.fade_stop);
   assign diff_mag  = (stop_pct >= start_pct) ? stop_pct - start_pct : start_pct - stop_pct;

   assign span_ok = (out_max_ff >= out_min_ff);
   assign span    = out_max_ff - out_min_ff;

   // tick: level +/- |step| * elapsed, saturated to 0..100, then stop test
   assign up_sum = {1'b0, mul_prod} + (PROD_W + 1)'(level_ff);
   assign lim    = pct_lvl(stop_ff);

   always_comb begin
      if (!step_neg_ff)
         tick_lvl = (up_sum > (PROD_W + 1)'(LVL_TOP)) ? LVL_TOP : up_sum[LVL_W-1:0];
      else
         tick_lvl = (mul_prod > PROD_W'(level_ff)) ? '0
                                                   : level_ff - mul_prod[LVL_W-1:0];
      tick_end = step_neg_ff ? (tick_lvl <= lim) : (tick_lvl >= lim);
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      step_mag_in  = step_mag_ff;
      step_neg_in  = step_neg_ff;
      stop_in      = stop_ff;
      drive_in     = drive_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_start_in = 1'b0;
      div_n_in     = div_n_ff;
      div_d_in     = div_d_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      drv_go       = 1'b0;
      drv_lvl      = level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.cmd)
                  lfd_pkg::CMD_SET: begin
                     step_mag_in = '0;
                     step_neg_in = 1'b0;
                     priority if (req_data.level[DATA_W-1]) begin
                        level_in = '0;
                        drive_in = out_min_ff;
                        state_in = ST_EMIT;
                     end else if (req_data.level > $signed(16'sd100)) begin
                        level_in = LVL_TOP;
                        drive_in = out_max_ff;
                        state_in = ST_EMIT;
                     end else begin
                        level_in = pct_lvl(set_pct);
                        drv_go   = 1'b1;
                        drv_lvl  = pct_lvl(set_pct);
                     end
                  end
                  lfd_pkg::CMD_FADE: begin
                     if (req_data.fade_ms == '0) begin
                        // zero length: same as a set to the stop
                        step_mag_in = '0;
                        step_neg_in = 1'b0;
                        level_in    = pct_lvl(stop_pct);
                        drv_go      = 1'b1;
                        drv_lvl     = pct_lvl(stop_pct);
                     end else begin
                        level_in     = pct_lvl(start_pct);
                        step_neg_in  = (stop_pct < start_pct);
                        stop_in      = stop_pct;
                        div_n_in     = pct_lvl(diff_mag);
                        div_d_in     = req_data.fade_ms;
                        div_start_in = 1'b1;
                        state_in     = ST_STEP_DIV;
                     end
                  end
                  lfd_pkg::CMD_TICK: begin
                     if (step_mag_ff != '0) begin
                        mul_a_in     = step_mag_ff;
                        mul_b_in     = req_data.elapsed_ms;
                        mul_start_in = 1'b1;
                        state_in     = ST_TICK_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_TICK_MUL: begin
            if (mul_stat.done) begin
               level_in = tick_lvl;
               if (tick_end) begin
                  step_mag_in = '0;
                  step_neg_in = 1'b0;
                  stop_in     = '0;
               end
               drv_go  = 1'b1;
               drv_lvl = tick_lvl;
            end
         end
         ST_STEP_DIV: begin
            if (div_stat.done) begin
               step_mag_in = div_quo;
               if (div_quo == '0) stop_in = '0;
               drv_go = 1'b1;
            end
         end
         ST_DRV_MUL: begin
            if (mul_stat.done) begin
               // span * level / (100 << F) == (span * level >> F) / 100
               div_n_in     = LVL_W'(mul_prod[PROD_W-1:FRAC_BITS]);
               div_d_in     = lfd_pkg::DRIVE_DIV;
               div_start_in = 1'b1;
               state_in     = ST_DRV_DIV;
            end
         end
         ST_DRV_DIV: begin
            if (div_stat.done) begin
               drive_in = div_quo[DATA_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.drive_value = drive_ff;
               rsp_data_in.level_pct   = level_ff[LVL_W-1 -: PCT_W];
               rsp_data_in.fading      = (step_mag_ff != '0);
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (drv_go) begin
         if (span_ok) begin
            mul_a_in     = drv_lvl;
            mul_b_in     = span;
            mul_start_in = 1'b1;
            state_in     = ST_DRV_MUL;
         end else begin
            drive_in = '0;
            state_in = ST_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      drive_ff     <= drive_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      div_n_ff     <= div_n_in;
      div_d_ff     <= div_d_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         step_mag_ff  <= '0;
         step_neg_ff  <= 1'b0;
         stop_ff      <= '0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         step_mag_ff  <= step_mag_in;
         step_neg_ff  <= step_neg_in;
         stop_ff      <= stop_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_TOP)
      else $error("level above full scale");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
      else $error("arithmetic unit busy while idle");

   a_rsp_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.level_pct <= lfd_pkg::PCT_MAX))
      else $error("reported level above 100");

endmodule

`default_nettype wire

FILE: tb/lfd_checker.sv
`timescale 1ns / 1ps
// lfd_checker: scoreboard for linear_fade_dimmer. Tracks register writes, predicts
// the response of every accepted request that gives one and compares it with the DUT output.
// Depends on lfd_pkg.

module lfd_checker
   import lfd_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic             pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]      pwdata,
   output int               fail_count,
   output int               pending
);

   localparam longint FULL_FX = longint'(100) << FRAC_BITS;

   longint      lvl_fx;     // lamp level, unsigned fixed point
   longint      step_fx;    // signed per-ms step, zero when no fade runs
   longint      stop_pct;
   logic [15:0] out_lo;
   logic [15:0] out_hi;
   rsp_type     lamp_outputs_due[$];
   int          errs;

   function automatic longint clamp_pct(input longint p);
      return (p < 0) ? 0 : ((p > 100) ? 100 : p);
   endfunction

   // inverted range gives zero drive
   function automatic logic [15:0] scaled_drive();
      longint span;
      if (out_hi < out_lo) return '0;
      span = longint'(out_hi) - longint'(out_lo);
      return 16'((span * lvl_fx) / FULL_FX);
   endfunction

   function automatic rsp_type lamp_result(input logic [15:0] drv);
      rsp_type r;
      r.drive_value = drv;
      r.level_pct   = 7'(lvl_fx >>> FRAC_BITS);
      r.fading      = (step_fx != 0);
      return r;
   endfunction

   function automatic rsp_type apply_level(input longint p);
      step_fx = 0;
      if (p > 100) begin
         lvl_fx = FULL_FX;
         return lamp_result(out_hi);
      end
      if (p < 0) begin
         lvl_fx = 0;
         return lamp_result(out_lo);
      end
      lvl_fx = p << FRAC_BITS;
      return lamp_result(scaled_drive());
   endfunction

   function automatic bit lamp_update(input req_type it, output rsp_type r);
      longint start;
      longint stop;
      longint ms;
      longint diff;
      longint mag;
      longint lim;
      r = '0;
      case (it.cmd)
         CMD_SET: begin
            r = apply_level(longint'($signed(it.level)));
            return 1'b1;
         end
         CMD_FADE: begin
            start = clamp_pct(longint'($signed(it.fade_start)));
            stop  = clamp_pct(longint'($signed(it.fade_stop)));
            ms    = longint'(it.fade_ms);
            if (ms == 0) begin
               r = apply_level(stop);
               return 1'b1;
            end
            lvl_fx   = start << FRAC_BITS;
            diff     = stop - start;
            mag      = ((diff < 0 ? -diff : diff) << FRAC_BITS) / ms;
            step_fx  = (diff < 0) ? -mag : mag;
            stop_pct = (step_fx != 0) ? stop : 0;
            r = lamp_result(scaled_drive());
            return 1'b1;
         end
         CMD_TICK: begin
            if (step_fx == 0) return 1'b0;
            lvl_fx += step_fx * longint'(it.elapsed_ms);
            if (lvl_fx < 0) lvl_fx = 0;
            if (lvl_fx > FULL_FX) lvl_fx = FULL_FX;
            // fade ends once the stop is reached or passed; overshoot is kept
            lim = stop_pct << FRAC_BITS;
            if ((step_fx > 0 && lvl_fx >= lim) || (step_fx < 0 && lvl_fx <= lim)) begin
               step_fx  = 0;
               stop_pct = 0;
            end
            r = lamp_result(scaled_drive());
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want_v,
                                         input logic [31:0] got_v);
      if (got_v !== want_v) begin
         errs++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : track
      rsp_type want;
      if (reset) begin
         lvl_fx   = 0;
         step_fx  = 0;
         stop_pct = 0;
         out_lo   = 16'd0;
         out_hi   = 16'd255;
         lamp_outputs_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lamp_outputs_due.size() == 0) begin
               errs++;
               $display("%0t: unexpected transaction: expected none, actual %0d/%0d/%0d",
                        $time, rsp_data.drive_value, rsp_data.level_pct, rsp_data.fading);
            end else begin
               want = lamp_outputs_due.pop_front();
               compare_field("drive_value", 32'(want.drive_value), 32'(rsp_data.drive_value));
               compare_field("level_pct", 32'(want.level_pct), 32'(rsp_data.level_pct));
               compare_field("fading", 32'(want.fading), 32'(rsp_data.fading));
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_OUT_MIN) out_lo = pwdata[15:0];
            else out_hi = pwdata[15:0];
         end
         if (req_valid && !req_stall) begin
            if (lamp_update(req_data, want)) lamp_outputs_due.push_back(want);
         end
      end
      pending    <= lamp_outputs_due.size();
      fail_count <= errs;
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for linear_fade_dimmer; drives requests, response
// stalls and register writes. Depends on lfd_pkg, lfd_checker and the DUT.

module tb;
   import lfd_pkg::*;

   localparam int unsigned FRAC_BITS = 24;
   localparam logic [1:0]  CMD_UNUSED = 2'd3;
   localparam int PHASE_ITEMS   = 240;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 5000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   int fail_count;
   int pending;
   int real_items;
   int idle_cycles;
   bit send_gaps;
   bit rsp_gaps;
   bit hold_rsp;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   linear_fade_dimmer #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   lfd_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pwrite && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // response side: random stall runs, plus one long hold when asked
   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (gap_len()) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type rand_item();
      req_type it;
      it.cmd        = 2'($urandom());
      it.level      = 16'($urandom());
      it.fade_start = 16'($urandom());
      it.fade_stop  = 16'($urandom());
      it.fade_ms    = 24'($urandom());
      it.elapsed_ms = 16'($urandom());
      return it;
   endfunction

   function automatic req_type mk_set(input int p);
      req_type it;
      it = rand_item();
      it.cmd   = CMD_SET;
      it.level = 16'(p);
      return it;
   endfunction

   function automatic req_type mk_fade(input int a, input int b, input int ms);
      req_type it;
      it = rand_item();
      it.cmd        = CMD_FADE;
      it.fade_start = 16'(a);
      it.fade_stop  = 16'(b);
      it.fade_ms    = 24'(ms);
      return it;
   endfunction

   function automatic req_type mk_tick(input int el);
      req_type it;
      it = rand_item();
      it.cmd        = CMD_TICK;
      it.elapsed_ms = 16'(el);
      return it;
   endfunction

   function automatic req_type mk_unused();
      req_type it;
      it = rand_item();
      it.cmd = CMD_UNUSED;
      return it;
   endfunction

   // mostly near the 0..100 window, sometimes anything
   function automatic int pct_field();
      if ($urandom_range(0, 3) == 0) return int'($signed(16'($urandom())));
      return int'($urandom_range(0, 115)) - 5;
   endfunction

   function automatic int fade_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 70) return $urandom_range(1, 3000);
      if (r < 90) return $urandom_range(3001, 200000);
      return int'(24'($urandom()));
   endfunction

   function automatic int tick_len(input int ms);
      int r;
      int cap;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 25) return int'(16'($urandom()));
      cap = ms / 3 + 1;
      if (cap > 65535) cap = 65535;
      return $urandom_range(0, cap);
   endfunction

   // call in the time step of a rising edge; returns at the accepting edge, or after a random gap when gaps are on
   task automatic send_item(input req_type it);
      int gap;
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (it.cmd != CMD_UNUSED) real_items++;
      if (send_gaps && $urandom_range(0, 1) == 0) begin
         gap = gap_len();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // returns with psel low again so back to back calls stay clean
   task automatic csr_write(input logic idx, input logic [15:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom()), val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // wait for the block to drain; idle ticks give no response, so pad after
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic one_sequence();
      int r;
      int ms;
      int ticks;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         ms = fade_len();
         send_item(mk_fade(pct_field(), pct_field(), ms));
         ticks = $urandom_range(1, 10);
         repeat (ticks) begin
            if ($urandom_range(0, 19) == 0) send_item(mk_set(pct_field()));
            else send_item(mk_tick(tick_len(ms)));
         end
      end else if (r < 85) begin
         send_item(mk_set(pct_field()));
      end else if (r < 93) begin
         send_item(mk_tick(tick_len(1000)));
      end else begin
         send_item(mk_unused());
      end
   endtask

   task automatic run_random(input int n);
      int target;
      target = real_items + n;
      while (real_items < target) one_sequence();
   endtask

   // receiver holds off while requests keep coming, so the DUT backs up
   task automatic pressure_burst();
      send_gaps = 1'b0;
      hold_rsp  = 1'b1;
      send_item(mk_fade(0, 100, 2000));
      repeat (24) send_item(mk_tick(50));
   endtask

   initial begin : main
      logic [15:0] lo;
      logic [15:0] hi;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;
      hold_rsp  = 1'b0;
      real_items = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      send_item(mk_set(0));
      send_item(mk_set(100));
      send_item(mk_set(37));
      send_item(mk_set(101));
      send_item(mk_set(-1));
      send_item(mk_set(32767));
      send_item(mk_set(-32768));
      send_item(mk_tick(100));               // no fade running
      send_item(mk_unused());
      send_item(mk_fade(0, 100, 1000));
      send_item(mk_tick(0));
      send_item(mk_tick(250));
      send_item(mk_tick(65535));             // overshoot, clamps at 100
      send_item(mk_fade(100, 0, 500));
      send_item(mk_tick(250));
      send_item(mk_tick(250));               // stops just short of the stop, fade keeps running
      send_item(mk_fade(-32768, 32767, 0));  // zero time acts as set
      send_item(mk_fade(40, 40, 10));        // zero step, no fade
      send_item(mk_tick(5));
      send_item(mk_fade(32767, -32768, 16777215));
      send_item(mk_tick(65535));
      send_item(mk_fade(80, 0, 3));
      send_item(mk_tick(65535));             // undershoot, clamps at 0
      send_item(mk_fade(0, 1, 16777215));    // smallest nonzero step
      send_item(mk_tick(65535));
      run_random(PHASE_ITEMS);

      for (int ph = 0; ph < 7; ph++) begin
         settle();
         case (ph)
            0: begin
               lo = 16'd0;
               hi = 16'd65535;
            end
            1: begin
               lo = 16'd65535;
               hi = 16'd0;
            end
            2: begin
               lo = 16'd1000;
               hi = 16'd200;
            end
            3: begin
               lo = 16'd300;
               hi = 16'd4000;
            end
            4: begin
               lo = 16'd65535;
               hi = 16'd65535;
            end
            5: begin
               lo = 16'd0;
               hi = 16'd0;
            end
            default: begin
               lo = 16'($urandom());
               hi = 16'($urandom());
            end
         endcase
         csr_write(REG_OUT_MIN, lo);
         csr_write(REG_OUT_MAX, hi);
         @(posedge clock);
         if (ph == 1) pressure_burst();
         // first phase runs back to back on both sides
         send_gaps = (ph != 0);
         rsp_gaps  = (ph != 0);
         run_random(PHASE_ITEMS);
      end

      settle();
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/lfd_pkg.sv
hdl/lfd_mul.sv
hdl/lfd_div.sv
hdl/linear_fade_dimmer.sv
tb/lfd_checker.sv
tb/tb.sv
